@@ rtl/spq_pkg.sv @@
package spq_pkg;

    localparam int ENTRY_ACCT_W = 16;
    localparam int ENTRY_PRIO_W = 8;
    localparam int ENTRY_HDL_W  = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 3;
    localparam int OCC_W        = 5;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic                load;
        logic                exec;
        logic                ins;
        logic                deq;
        logic                clr;
        logic [STATUS_W-1:0] code;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
    } t_stat;

endpackage

@@ rtl/spq_ctrl.sv @@
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output spq_pkg::t_cmd o_cmd,
    input  spq_pkg::t_stat i_stat
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;
    logic            r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == spq_pkg::S_EXEC);
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = spq_pkg::S_IDLE;
                if (i_stat.op[1]) begin
                    // code 3 decodes as clear too
                    o_cmd.clr  = 1'b1;
                    o_cmd.code = spq_pkg::ST_CLEARED;
                end else if (i_stat.op == spq_pkg::OP_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.code = spq_pkg::ST_FULL;
                    end else begin
                        o_cmd.ins  = 1'b1;
                        o_cmd.code = spq_pkg::ST_INSERTED;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.code = spq_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.deq  = 1'b1;
                        o_cmd.code = spq_pkg::ST_DEQUEUED;
                    end
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != spq_pkg::S_IDLE);
    assign o_done = r_done;

endmodule

@@ rtl/spq_datapath.sv @@
module spq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spq_pkg::t_cmd                    i_cmd,
    output spq_pkg::t_stat                   o_stat,
    input  logic [spq_pkg::OP_W-1:0]         i_operation,
    input  logic [spq_pkg::ENTRY_ACCT_W-1:0] i_account_id,
    input  logic [spq_pkg::ENTRY_PRIO_W-1:0] i_priority_req,
    input  logic [spq_pkg::ENTRY_HDL_W-1:0]  i_message_handle,
    output logic [spq_pkg::STATUS_W-1:0]     o_status,
    output logic [spq_pkg::ENTRY_ACCT_W-1:0] o_out_account_id,
    output logic [spq_pkg::ENTRY_PRIO_W-1:0] o_out_priority,
    output logic [spq_pkg::ENTRY_HDL_W-1:0]  o_out_message_handle,
    output logic [spq_pkg::OCC_W-1:0]        o_occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [spq_pkg::ENTRY_ACCT_W-1:0] r_acct [QUEUE_DEPTH];
    logic [spq_pkg::ENTRY_PRIO_W-1:0] r_prio [QUEUE_DEPTH];
    logic [spq_pkg::ENTRY_HDL_W-1:0]  r_hdl  [QUEUE_DEPTH];
    logic [spq_pkg::ENTRY_ACCT_W-1:0] n_acct [QUEUE_DEPTH];
    logic [spq_pkg::ENTRY_PRIO_W-1:0] n_prio [QUEUE_DEPTH];
    logic [spq_pkg::ENTRY_HDL_W-1:0]  n_hdl  [QUEUE_DEPTH];

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic [spq_pkg::OP_W-1:0]         r_op;
    logic [spq_pkg::ENTRY_ACCT_W-1:0] r_in_acct;
    logic [spq_pkg::ENTRY_PRIO_W-1:0] r_in_prio;
    logic [spq_pkg::ENTRY_HDL_W-1:0]  r_in_hdl;

    logic [spq_pkg::STATUS_W-1:0]     r_status;
    logic [spq_pkg::ENTRY_ACCT_W-1:0] r_out_acct;
    logic [spq_pkg::ENTRY_PRIO_W-1:0] r_out_prio;
    logic [spq_pkg::ENTRY_HDL_W-1:0]  r_out_hdl;
    logic [spq_pkg::OCC_W-1:0]        r_occ;

    logic [QUEUE_DEPTH-1:0] w_ge;
    logic [QUEUE_DEPTH-1:0] w_prev_ge;
    logic [CW+spq_pkg::OCC_W-1:0] w_count_ext;

    // entry stays put when it is valid and ranks at or above the new one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_ge[i] = (r_count > CW'(i)) && (r_prio[i] >= r_in_prio);
        end
    end

    assign w_prev_ge = {w_ge[QUEUE_DEPTH-2:0], 1'b1};

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic [spq_pkg::ENTRY_ACCT_W-1:0] w_up_acct;
            logic [spq_pkg::ENTRY_PRIO_W-1:0] w_up_prio;
            logic [spq_pkg::ENTRY_HDL_W-1:0]  w_up_hdl;
            logic [spq_pkg::ENTRY_ACCT_W-1:0] w_dn_acct;
            logic [spq_pkg::ENTRY_PRIO_W-1:0] w_dn_prio;
            logic [spq_pkg::ENTRY_HDL_W-1:0]  w_dn_hdl;

            if (g == 0) begin : g_first
                assign w_up_acct = r_in_acct;
                assign w_up_prio = r_in_prio;
                assign w_up_hdl  = r_in_hdl;
            end else begin : g_mid
                assign w_up_acct = r_acct[g-1];
                assign w_up_prio = r_prio[g-1];
                assign w_up_hdl  = r_hdl[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_dn_acct = r_acct[g];
                assign w_dn_prio = r_prio[g];
                assign w_dn_hdl  = r_hdl[g];
            end else begin : g_body
                assign w_dn_acct = r_acct[g+1];
                assign w_dn_prio = r_prio[g+1];
                assign w_dn_hdl  = r_hdl[g+1];
            end

            always_comb begin
                n_acct[g] = r_acct[g];
                n_prio[g] = r_prio[g];
                n_hdl[g]  = r_hdl[g];
                if (i_cmd.ins && !w_ge[g]) begin
                    if (w_prev_ge[g]) begin
                        n_acct[g] = r_in_acct;
                        n_prio[g] = r_in_prio;
                        n_hdl[g]  = r_in_hdl;
                    end else begin
                        n_acct[g] = w_up_acct;
                        n_prio[g] = w_up_prio;
                        n_hdl[g]  = w_up_hdl;
                    end
                end else if (i_cmd.deq) begin
                    n_acct[g] = w_dn_acct;
                    n_prio[g] = w_dn_prio;
                    n_hdl[g]  = w_dn_hdl;
                end
            end

            always_ff @(posedge i_clk) begin
                r_acct[g] <= n_acct[g];
                r_prio[g] <= n_prio[g];
                r_hdl[g]  <= n_hdl[g];
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_cmd.clr) begin
            n_count = '0;
        end else if (i_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_count_ext = (CW + spq_pkg::OCC_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_in_acct <= i_account_id;
            r_in_prio <= i_priority_req;
            r_in_hdl  <= i_message_handle;
        end
        if (i_cmd.exec) begin
            r_status <= i_cmd.code;
            r_occ    <= w_count_ext[spq_pkg::OCC_W-1:0];
            if (i_cmd.deq) begin
                r_out_acct <= r_acct[0];
                r_out_prio <= r_prio[0];
                r_out_hdl  <= r_hdl[0];
            end else begin
                r_out_acct <= '0;
                r_out_prio <= '0;
                r_out_hdl  <= '0;
            end
        end
    end

    assign o_stat.op    = r_op;
    assign o_stat.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    assign o_status             = r_status;
    assign o_out_account_id     = r_out_acct;
    assign o_out_priority       = r_out_prio;
    assign o_out_message_handle = r_out_hdl;
    assign o_occupancy          = r_occ;

endmodule

@@ rtl/sorted_priority_queue_unit.sv @@
// Sorted priority queue of up to QUEUE_DEPTH message entries, highest priority
// at the head; equal priorities leave in arrival order. Pulse start with an
// operation (insert, dequeue, clear) while busy is low; busy stays high while
// the entry array compares and shifts all cells in parallel, and the result
// appears in the cycle after that, on o_done for a single cycle. The
// receiver cannot stall: capture the result whenever o_done is high. A new
// operation is taken only when busy is low, after the single compare-and-shift
// step of the entry array. Occupancy shows the low 5 bits of the entry count.
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_account_id,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_message_handle,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_account_id,
    output logic [7:0]  o_out_priority,
    output logic [31:0] o_out_message_handle,
    output logic [4:0]  o_occupancy
);

    spq_pkg::t_cmd  w_cmd;
    spq_pkg::t_stat w_stat;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_operation          (i_operation),
        .i_account_id         (i_account_id),
        .i_priority_req       (i_priority_req),
        .i_message_handle     (i_message_handle),
        .o_status             (o_status),
        .o_out_account_id     (o_out_account_id),
        .o_out_priority       (o_out_priority),
        .o_out_message_handle (o_out_message_handle),
        .o_occupancy          (o_occupancy)
    );

endmodule

@@ rtl/spq_checker.sv @@
module spq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [15:0] o_out_account_id,
    input logic [7:0]  o_out_priority,
    input logic [31:0] o_out_message_handle,
    input logic [4:0]  o_occupancy
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result not delivered two cycles after transfer");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != spq_pkg::ST_DEQUEUED) |->
        (o_out_account_id == '0 && o_out_priority == '0 && o_out_message_handle == '0))
        else $error("entry fields nonzero on non-dequeue result");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == spq_pkg::ST_EMPTY || o_status == spq_pkg::ST_CLEARED))
        |-> o_occupancy == '0)
        else $error("occupancy nonzero on empty or cleared result");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .start                (start),
    .busy                 (busy),
    .o_done               (o_done),
    .o_status             (o_status),
    .o_out_account_id     (o_out_account_id),
    .o_out_priority       (o_out_priority),
    .o_out_message_handle (o_out_message_handle),
    .o_occupancy          (o_occupancy)
);
